FILE: hdl/ldr_pkg.sv
package ldr_pkg;

   localparam int LEASE_SLOTS = 64;
   localparam int SLOT_W = $clog2(LEASE_SLOTS);
   localparam int CNT_W = $clog2(LEASE_SLOTS + 1);

   localparam int ID_W = 31;
   localparam int CLIENT_W = 16;
   localparam int CHUNK_W = 21;
   localparam int TIME_W = 32;
   localparam int EXPIRY_W = 33;
   localparam int STATUS_W = 3;
   localparam int MOVED_W = 7;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] CMD_REQUEST = 2'd0;
   localparam logic [1:0] CMD_COMMIT = 2'd1;
   localparam logic [1:0] CMD_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK = 3'd0;
   localparam logic [STATUS_W-1:0] ST_STOPPED = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NO_RANGE = 3'd2;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN_TASK = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLIENT_MISMATCH = 3'd4;
   localparam logic [STATUS_W-1:0] ST_TABLE_FULL = 3'd5;

   localparam logic [CSR_IDX_W-1:0] CSR_RUNNING = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RANGE_END = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POSITION = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_TASK_ID = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LEASE_TIMEOUT = 3'd4;

   localparam logic [TIME_W-1:0] TIMEOUT_RESET = 32'd60;

   typedef struct packed {
      logic [ID_W-1:0]     task_id;
      logic [CLIENT_W-1:0] client;
      logic [ID_W-1:0]     first;
      logic [ID_W-1:0]     limit;
      logic [EXPIRY_W-1:0] expiry;
   } lease_type;

   typedef struct packed {
      logic [ID_W-1:0] first;
      logic [ID_W-1:0] limit;
   } range_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_POP_RD,
      S_POP_TAKE,
      S_FREE_SCAN,
      S_HIT_RD,
      S_HIT_EV,
      S_MARK_RD,
      S_MARK_EV,
      S_SEL_RD,
      S_SEL_EV,
      S_PUSH,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic                latch;
      logic                status_wr;
      logic [STATUS_W-1:0] status_sel;
      logic                fresh;
      logic                pop_take;
      logic                free_chk;
      logic                scan_clr;
      logic                scan_inc;
      logic                hit_ev;
      logic                mark_ev;
      logic                sel_ev;
      logic                push;
      logic                load_out;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       running;
      logic       fifo_nonempty;
      logic       no_range;
      logic       table_full;
      logic       scan_last;
      logic       slot_free;
      logic       hit;
      logic       best_found;
      logic       out_free;
   } dp_sts_type;

endpackage

FILE: hdl/ldr_ifs.sv
interface ldr_req_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    cmd;
   logic [ldr_pkg::CLIENT_W-1:0]  client;
   logic [ldr_pkg::CHUNK_W-1:0]   chunk_size;
   logic [ldr_pkg::ID_W-1:0]      task_id;
   logic [ldr_pkg::TIME_W-1:0]    time_now;

   modport source (output valid, cmd, client, chunk_size, task_id, time_now, input ready);
   modport sink (input valid, cmd, client, chunk_size, task_id, time_now, output ready);
endinterface

interface ldr_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ldr_pkg::STATUS_W-1:0]  status;
   logic [ldr_pkg::ID_W-1:0]      granted_task;
   logic [ldr_pkg::ID_W-1:0]      range_first;
   logic [ldr_pkg::ID_W-1:0]      range_limit;
   logic [ldr_pkg::ID_W-1:0]      position_now;
   logic [ldr_pkg::MOVED_W-1:0]   moved_count;

   modport source (output valid, status, granted_task, range_first, range_limit,
                   position_now, moved_count, input ready);
   modport sink (input valid, status, granted_task, range_first, range_limit,
                 position_now, moved_count, output ready);
endinterface

interface ldr_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ldr_pkg::CSR_IDX_W-1:0]   index;
   logic [ldr_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/ldr_ram.sv
module ldr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

FILE: hdl/ldr_ctrl.sv
module ldr_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ldr_pkg::dp_sts_type sts,
   output ldr_pkg::dp_cmd_type cmd
);
   import ldr_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) state_in = S_DECIDE;
         end
         S_DECIDE: begin
            case (sts.op)
               CMD_REQUEST: begin
                  if (!sts.running) state_in = S_FINISH;
                  else if (sts.fifo_nonempty) state_in = S_POP_RD;
                  else if (sts.no_range || sts.table_full) state_in = S_FINISH;
                  else state_in = S_FREE_SCAN;
               end
               CMD_COMMIT: state_in = S_HIT_RD;
               CMD_RELEASE: state_in = S_MARK_RD;
               default: state_in = S_FINISH;
            endcase
         end
         S_POP_RD: state_in = S_POP_TAKE;
         S_POP_TAKE: state_in = S_FREE_SCAN;
         S_FREE_SCAN: begin
            if (sts.slot_free) state_in = S_FINISH;
         end
         S_HIT_RD: state_in = S_HIT_EV;
         S_HIT_EV: begin
            if (sts.hit || sts.scan_last) state_in = S_MARK_RD;
            else state_in = S_HIT_RD;
         end
         S_MARK_RD: state_in = S_MARK_EV;
         S_MARK_EV: begin
            if (sts.scan_last) state_in = S_SEL_RD;
            else state_in = S_MARK_RD;
         end
         S_SEL_RD: state_in = S_SEL_EV;
         S_SEL_EV: begin
            if (sts.scan_last) state_in = S_PUSH;
            else state_in = S_SEL_RD;
         end
         S_PUSH: begin
            if (sts.best_found) state_in = S_SEL_RD;
            else state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_valid;
         end
         S_DECIDE: begin
            cmd.scan_clr = 1'b1;
            if (sts.op == CMD_REQUEST) begin
               if (!sts.running) begin
                  cmd.status_wr = 1'b1;
                  cmd.status_sel = ST_STOPPED;
               end else if (sts.fifo_nonempty) begin
                  cmd.status_wr = 1'b0;
               end else if (sts.no_range) begin
                  cmd.status_wr = 1'b1;
                  cmd.status_sel = ST_NO_RANGE;
               end else if (sts.table_full) begin
                  cmd.status_wr = 1'b1;
                  cmd.status_sel = ST_TABLE_FULL;
               end else begin
                  cmd.fresh = 1'b1;
               end
            end
         end
         S_POP_RD: cmd.status_wr = 1'b0;
         S_POP_TAKE: cmd.pop_take = 1'b1;
         S_FREE_SCAN: begin
            cmd.free_chk = 1'b1;
            cmd.scan_inc = !sts.slot_free;
         end
         S_HIT_RD: cmd.status_wr = 1'b0;
         S_HIT_EV: begin
            cmd.hit_ev = 1'b1;
            if (sts.hit) begin
               cmd.scan_clr = 1'b1;
            end else if (sts.scan_last) begin
               cmd.status_wr = 1'b1;
               cmd.status_sel = ST_UNKNOWN_TASK;
               cmd.scan_clr = 1'b1;
            end else begin
               cmd.scan_inc = 1'b1;
            end
         end
         S_MARK_RD: cmd.status_wr = 1'b0;
         S_MARK_EV: begin
            cmd.mark_ev = 1'b1;
            cmd.scan_clr = sts.scan_last;
            cmd.scan_inc = !sts.scan_last;
         end
         S_SEL_RD: cmd.status_wr = 1'b0;
         S_SEL_EV: begin
            cmd.sel_ev = 1'b1;
            cmd.scan_inc = !sts.scan_last;
         end
         S_PUSH: begin
            cmd.push = sts.best_found;
            cmd.scan_clr = 1'b1;
         end
         S_FINISH: cmd.load_out = sts.out_free;
         default: cmd.status_wr = 1'b0;
      endcase
   end
endmodule

FILE: hdl/ldr_dp.sv
module ldr_dp (
   input  logic                clock,
   input  logic                reset,
   input  ldr_pkg::dp_cmd_type cmd,
   output ldr_pkg::dp_sts_type sts,
   ldr_req_if.sink             req,
   ldr_rsp_if.source           rsp,
   ldr_csr_if.sink             csr
);
   import ldr_pkg::*;

   logic                running_ff;
   logic [ID_W-1:0]     range_end_ff;
   logic [TIME_W-1:0]   timeout_ff;
   logic [ID_W-1:0]     next_pos_ff;
   logic [ID_W-1:0]     next_task_ff;

   logic [1:0]          op_ff;
   logic [CLIENT_W-1:0] client_ff;
   logic [CHUNK_W-1:0]  chunk_ff;
   logic [ID_W-1:0]     task_ff;
   logic [TIME_W-1:0]   now_ff;

   logic [LEASE_SLOTS-1:0] valid_ff;
   logic [LEASE_SLOTS-1:0] marked_ff;
   logic [CNT_W-1:0]    in_use_ff;
   logic [SLOT_W-1:0]   head_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [SLOT_W-1:0]   scan_ff;

   logic                best_found_ff;
   logic [ID_W-1:0]     best_task_ff;
   logic [ID_W-1:0]     best_first_ff;
   logic [ID_W-1:0]     best_limit_ff;
   logic [SLOT_W-1:0]   best_slot_ff;

   logic [STATUS_W-1:0] status_ff;
   logic [ID_W-1:0]     gtask_ff;
   logic [ID_W-1:0]     gfirst_ff;
   logic [ID_W-1:0]     glimit_ff;
   logic [CNT_W-1:0]    moved_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ID_W-1:0]     rsp_task_ff;
   logic [ID_W-1:0]     rsp_first_ff;
   logic [ID_W-1:0]     rsp_limit_ff;
   logic [ID_W-1:0]     rsp_pos_ff;
   logic [MOVED_W-1:0]  rsp_moved_ff;

   lease_type           lease_rd;
   lease_type           lease_wr;
   logic                lease_we;
   range_type           fifo_rd;
   range_type           fifo_wr;
   logic                fifo_we;
   logic [SLOT_W-1:0]   tail;
   logic [CNT_W:0]      tail_sum;
   logic [ID_W:0]       stop;
   logic [ID_W-1:0]     fresh_limit;
   logic                hit;
   logic                out_free;

   assign csr.ready = 1'b1;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign hit = valid_ff[scan_ff] && (lease_rd.task_id == task_ff);

   assign stop = {1'b0, next_pos_ff} + (ID_W+1)'(chunk_ff);
   assign fresh_limit = (stop > {1'b0, range_end_ff}) ? range_end_ff : stop[ID_W-1:0];

   assign tail_sum = (CNT_W+1)'(head_ff) + (CNT_W+1)'(count_ff);
   assign tail = (tail_sum >= (CNT_W+1)'(LEASE_SLOTS))
                 ? SLOT_W'(tail_sum - (CNT_W+1)'(LEASE_SLOTS)) : SLOT_W'(tail_sum);

   assign lease_we = cmd.free_chk && !valid_ff[scan_ff];
   assign lease_wr = '{task_id: next_task_ff, client: client_ff, first: gfirst_ff,
                       limit: glimit_ff,
                       expiry: {1'b0, now_ff} + {1'b0, timeout_ff}};
   assign fifo_we = cmd.push && (count_ff < CNT_W'(LEASE_SLOTS));
   assign fifo_wr = '{first: best_first_ff, limit: best_limit_ff};

   ldr_ram #(.WIDTH($bits(lease_type)), .DEPTH(LEASE_SLOTS)) u_lease_ram (
      .clock(clock), .wr_en(lease_we), .wr_addr(scan_ff), .wr_data(lease_wr),
      .rd_addr(scan_ff), .rd_data(lease_rd)
   );

   ldr_ram #(.WIDTH($bits(range_type)), .DEPTH(LEASE_SLOTS)) u_fifo_ram (
      .clock(clock), .wr_en(fifo_we), .wr_addr(tail), .wr_data(fifo_wr),
      .rd_addr(head_ff), .rd_data(fifo_rd)
   );

   always_comb begin
      sts.op = op_ff;
      sts.running = running_ff;
      sts.fifo_nonempty = (count_ff != '0);
      sts.no_range = (next_pos_ff >= range_end_ff);
      sts.table_full = ((CNT_W+1)'(in_use_ff) + (CNT_W+1)'(count_ff))
                       >= (CNT_W+1)'(LEASE_SLOTS);
      sts.scan_last = (scan_ff == SLOT_W'(LEASE_SLOTS - 1));
      sts.slot_free = !valid_ff[scan_ff];
      sts.hit = hit;
      sts.best_found = best_found_ff;
      sts.out_free = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= 1'b1;
         range_end_ff <= '0;
         timeout_ff <= TIMEOUT_RESET;
         next_pos_ff <= '0;
         next_task_ff <= '0;
         valid_ff <= '0;
         marked_ff <= '0;
         in_use_ff <= '0;
         head_ff <= '0;
         count_ff <= '0;
         scan_ff <= '0;
         best_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            unique case (csr.index)
               CSR_RUNNING: running_ff <= csr.data[0];
               CSR_RANGE_END: range_end_ff <= csr.data[ID_W-1:0];
               CSR_START_POSITION: next_pos_ff <= csr.data[ID_W-1:0];
               CSR_FIRST_TASK_ID: next_task_ff <= csr.data[ID_W-1:0];
               CSR_LEASE_TIMEOUT: timeout_ff <= csr.data;
               default: ;
            endcase
         end

         if (cmd.scan_clr) begin
            scan_ff <= '0;
            best_found_ff <= 1'b0;
         end else if (cmd.scan_inc) begin
            scan_ff <= scan_ff + 1'b1;
         end

         if (cmd.fresh) begin
            next_pos_ff <= fresh_limit;
         end

         if (cmd.pop_take) begin
            head_ff <= (head_ff == SLOT_W'(LEASE_SLOTS - 1)) ? '0 : head_ff + 1'b1;
            count_ff <= count_ff - 1'b1;
         end

         if (lease_we) begin
            valid_ff[scan_ff] <= 1'b1;
            marked_ff[scan_ff] <= 1'b0;
            in_use_ff <= in_use_ff + 1'b1;
            next_task_ff <= next_task_ff + 1'b1;
         end

         if (cmd.hit_ev && hit && (lease_rd.client == client_ff)) begin
            valid_ff[scan_ff] <= 1'b0;
            in_use_ff <= in_use_ff - 1'b1;
         end

         if (cmd.mark_ev) begin
            if (op_ff == CMD_COMMIT) begin
               marked_ff[scan_ff] <= valid_ff[scan_ff] &&
                                     (lease_rd.expiry < {1'b0, now_ff});
            end else begin
               marked_ff[scan_ff] <= valid_ff[scan_ff] && (lease_rd.client == client_ff);
            end
         end

         if (cmd.sel_ev && valid_ff[scan_ff] && marked_ff[scan_ff] &&
             (!best_found_ff || lease_rd.task_id < best_task_ff)) begin
            best_found_ff <= 1'b1;
         end

         if (cmd.push) begin
            valid_ff[best_slot_ff] <= 1'b0;
            marked_ff[best_slot_ff] <= 1'b0;
            in_use_ff <= in_use_ff - 1'b1;
            if (fifo_we) begin
               count_ff <= count_ff + 1'b1;
            end
         end

         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         op_ff <= req.cmd;
         client_ff <= req.client;
         chunk_ff <= req.chunk_size;
         task_ff <= req.task_id;
         now_ff <= req.time_now;
         status_ff <= ST_OK;
         gtask_ff <= '0;
         gfirst_ff <= '0;
         glimit_ff <= '0;
         moved_ff <= '0;
      end else begin
         if (cmd.status_wr) begin
            status_ff <= cmd.status_sel;
         end
         if (cmd.hit_ev && hit && (lease_rd.client != client_ff)) begin
            status_ff <= ST_CLIENT_MISMATCH;
         end
         if (cmd.fresh) begin
            gfirst_ff <= next_pos_ff;
            glimit_ff <= fresh_limit;
         end
         if (cmd.pop_take) begin
            gfirst_ff <= fifo_rd.first;
            glimit_ff <= fifo_rd.limit;
         end
         if (lease_we) begin
            gtask_ff <= next_task_ff;
         end
         if (cmd.push) begin
            moved_ff <= moved_ff + 1'b1;
         end
      end

      if (cmd.sel_ev && valid_ff[scan_ff] && marked_ff[scan_ff] &&
          (!best_found_ff || lease_rd.task_id < best_task_ff)) begin
         best_task_ff <= lease_rd.task_id;
         best_first_ff <= lease_rd.first;
         best_limit_ff <= lease_rd.limit;
         best_slot_ff <= scan_ff;
      end

      if (cmd.load_out) begin
         rsp_status_ff <= status_ff;
         rsp_task_ff <= gtask_ff;
         rsp_first_ff <= gfirst_ff;
         rsp_limit_ff <= glimit_ff;
         rsp_pos_ff <= next_pos_ff;
         rsp_moved_ff <= MOVED_W'(moved_ff);
      end
   end

   assign rsp.valid = rsp_valid_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.granted_task = rsp_task_ff;
   assign rsp.range_first = rsp_first_ff;
   assign rsp.range_limit = rsp_limit_ff;
   assign rsp.position_now = rsp_pos_ff;
   assign rsp.moved_count = rsp_moved_ff;
endmodule

FILE: hdl/leased_range_dispatcher.sv
// Request: a returned range is read, then taken from the FIFO, then slots are scanned to
// the first free one; a fresh request skips the FIFO steps; a refused one goes to finish.
// Commit: a read and an evaluate step per slot to find the task, again per slot to mark,
// then per slot plus a push per selection pass (a pass per moved lease plus one). Release:
// marking and passes only. One request in flight, the next taken in the cycle after the
// response loads; a held response stalls input. Reset: synchronous, running on, timeout 60.
module leased_range_dispatcher (
   input logic       clock,
   input logic       reset,
   ldr_req_if.sink   req_ch,
   ldr_rsp_if.source rsp_ch,
   ldr_csr_if.sink   csr_ch
);
   import ldr_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       req_ready;

   assign req_ch.ready = req_ready;

   ldr_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_ch.valid), .req_ready(req_ready),
      .sts(sts), .cmd(cmd)
   );

   ldr_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .req(req_ch), .rsp(rsp_ch), .csr(csr_ch)
   );
endmodule
